// ----- hdl/srtf_pkg.sv -----
// srtf_pkg: shared types and constants for the srtf scheduler
// no dependencies
package srtf_pkg;
  localparam int unsigned MaxProcsDef = 16;
  localparam int unsigned IdW   = 8;
  localparam int unsigned TimeW = 16;
  localparam int unsigned ClkW  = 21;
  localparam int unsigned SumW  = 25;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_STEP,
    ST_EMIT
  } state_t;

  // candidate carried along the cell chain during a scan
  typedef struct packed {
    logic             have_best;
    logic [5:0]       best_idx;
    logic [TimeW-1:0] best_rem;
    logic             have_next;
    logic [TimeW-1:0] next_arr;
    logic             have_min;
    logic [TimeW-1:0] min_arr;
  } scan_t;

  // command from the controller to every cell
  typedef struct packed {
    logic             load;
    logic [5:0]       load_idx;
    logic             clear;
    logic             update;
    logic [5:0]       upd_idx;
    logic [TimeW-1:0] run;
  } cell_cmd_t;
endpackage

// ----- hdl/srtf_cell.sv -----
// srtf_cell: one process slot, holds its entry and compares it into the scan chain
// depends on srtf_pkg
module srtf_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned IdxW = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srtf_pkg::cell_cmd_t           cmd,
  input  logic [srtf_pkg::IdW-1:0]      ld_id,
  input  logic [srtf_pkg::TimeW-1:0]    ld_arr,
  input  logic [srtf_pkg::TimeW-1:0]    ld_burst,
  input  logic [IdxW:0]                 count,
  input  logic [srtf_pkg::ClkW-1:0]     now,
  input  srtf_pkg::scan_t               scan_in,
  output srtf_pkg::scan_t               scan_out,
  output logic [srtf_pkg::IdW-1:0]      id_o,
  output logic [srtf_pkg::TimeW-1:0]    arr_o,
  output logic [srtf_pkg::TimeW-1:0]    burst_o
);
  localparam logic [5:0] MyIdx = 6'(Idx);
  localparam logic [IdxW:0] MyCnt = (IdxW+1)'(Idx);
  logic [srtf_pkg::IdW-1:0]   id_r;
  logic [srtf_pkg::TimeW-1:0] arr_r, burst_r, rem_r;
  logic done_r;
  logic live;

  always_ff @(posedge clk) begin
    if (cmd.load && cmd.load_idx == MyIdx) begin
      id_r    <= ld_id;
      arr_r   <= ld_arr;
      burst_r <= ld_burst;
      rem_r   <= ld_burst;
    end else if (cmd.update && cmd.upd_idx == MyIdx) begin
      rem_r <= rem_r - cmd.run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      done_r <= 1'b0;
    end else if (cmd.update && cmd.upd_idx == MyIdx && rem_r == cmd.run) begin
      done_r <= 1'b1;
    end
  end

  assign live = (MyCnt < count) && !done_r;

  always_comb begin
    scan_out = scan_in;
    if (live) begin
      if (!scan_in.have_min || arr_r < scan_in.min_arr) begin
        scan_out.have_min = 1'b1;
        scan_out.min_arr  = arr_r;
      end
      if (srtf_pkg::ClkW'(arr_r) <= now) begin
        if (!scan_in.have_best || rem_r < scan_in.best_rem) begin
          scan_out.have_best = 1'b1;
          scan_out.best_idx  = MyIdx;
          scan_out.best_rem  = rem_r;
        end
      end else if (!scan_in.have_next || arr_r < scan_in.next_arr) begin
        scan_out.have_next = 1'b1;
        scan_out.next_arr  = arr_r;
      end
    end
  end

  assign id_o = id_r;
  assign arr_o = arr_r;
  assign burst_o = burst_r;
endmodule

// ----- hdl/srtf_scheduler.sv -----
// srtf_scheduler: shortest-remaining-time-first scheduler over a chain of process cells
// depends on srtf_pkg and srtf_cell
// loads are taken whenever in_tvalid is high in the load state; after the last
// load each scheduling event (a preemption point, an idle skip or a completion)
// runs a scan over the segments (registered candidate every 4 cells) and a
// step; each completion then emits a result, held while out_tready is low, and
// one more scan and step close the set before loads resume. reset (synchronous,
// rst_n low) empties the set and clears all counters.
module srtf_scheduler #(
  parameter int unsigned MAX_PROCS = srtf_pkg::MaxProcsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // process_id[7:0], arrival_time[23:8], burst_time[39:24]
  input  logic         in_tlast,   // last_process
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // done_id, waiting_time, turnaround_time,
                                   // total_waiting, total_turnaround, dropped_flag
  output logic         out_tlast   // last_result
);
  localparam int unsigned IdxW = $clog2(MAX_PROCS);
  localparam int unsigned Seg  = 4;
  localparam int unsigned NSeg = (MAX_PROCS + Seg - 1) / Seg;
  localparam int unsigned SegW = (NSeg > 1) ? $clog2(NSeg) : 1;

  srtf_pkg::state_t state_r, state_nxt;
  logic [IdxW:0] count_r, count_nxt;
  logic [IdxW:0] fin_r, fin_nxt;
  logic ovf_r, ovf_nxt;
  logic [srtf_pkg::ClkW-1:0] now_r, now_nxt;
  logic [srtf_pkg::SumW-1:0] sw_r, sw_nxt, st_r, st_nxt;
  logic [SegW-1:0] seg_r, seg_nxt;
  srtf_pkg::scan_t cand_r, cand_nxt;
  logic [103:0] odata_r, odata_nxt;
  logic olast_r, olast_nxt;
  srtf_pkg::cell_cmd_t cmd;

  srtf_pkg::scan_t chain [MAX_PROCS+1];
  srtf_pkg::scan_t seg_in [NSeg];
  logic [srtf_pkg::IdW-1:0]   ids  [MAX_PROCS];
  logic [srtf_pkg::TimeW-1:0] arrs [MAX_PROCS];
  logic [srtf_pkg::TimeW-1:0] brs  [MAX_PROCS];
  srtf_pkg::scan_t seg_out;

  genvar g;
  generate
    for (g = 0; g < NSeg; g++) begin : g_seg
      assign seg_in[g] = (seg_r == SegW'(g)) ? cand_r : '0;
    end
    for (g = 0; g < MAX_PROCS; g++) begin : g_cell
      srtf_pkg::scan_t cin;
      if (g % Seg == 0) begin : g_head
        assign cin = seg_in[g / Seg];
      end else begin : g_body
        assign cin = chain[g];
      end
      srtf_cell #(.Idx(g), .IdxW(IdxW)) u_cell (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .ld_id(in_tdata[7:0]), .ld_arr(in_tdata[23:8]), .ld_burst(in_tdata[39:24]),
        .count(count_r), .now(now_r),
        .scan_in(cin), .scan_out(chain[g+1]),
        .id_o(ids[g]), .arr_o(arrs[g]), .burst_o(brs[g])
      );
    end
  endgenerate
  assign chain[0] = '0;

  // select the tail of the active segment
  always_comb begin
    seg_out = '0;
    for (int s = 0; s < NSeg; s++) begin
      if (seg_r == SegW'(s)) seg_out = chain[((s + 1) * Seg > MAX_PROCS) ?
                                              MAX_PROCS : (s + 1) * Seg];
    end
  end

  logic [IdxW-1:0] bi;
  logic [srtf_pkg::ClkW-1:0] gap, run21, fin_t, turn, wait_t;
  logic [srtf_pkg::TimeW-1:0] run;
  assign bi = cand_r.best_idx[IdxW-1:0];
  assign gap = srtf_pkg::ClkW'(cand_r.next_arr) - now_r;
  assign run21 = (cand_r.have_next && gap < srtf_pkg::ClkW'(cand_r.best_rem)) ?
                 gap : srtf_pkg::ClkW'(cand_r.best_rem);
  assign run = run21[srtf_pkg::TimeW-1:0];
  assign fin_t = now_r + run21;
  assign turn = fin_t - srtf_pkg::ClkW'(arrs[bi]);
  assign wait_t = turn - srtf_pkg::ClkW'(brs[bi]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srtf_pkg::ST_LOAD;
      count_r <= '0;
      fin_r <= '0;
      ovf_r <= 1'b0;
      now_r <= '0;
      sw_r <= '0;
      st_r <= '0;
      seg_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      fin_r <= fin_nxt;
      ovf_r <= ovf_nxt;
      now_r <= now_nxt;
      sw_r <= sw_nxt;
      st_r <= st_nxt;
      seg_r <= seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    fin_nxt = fin_r;
    ovf_nxt = ovf_r;
    now_nxt = now_r;
    sw_nxt = sw_r;
    st_nxt = st_r;
    seg_nxt = seg_r;
    cand_nxt = cand_r;
    odata_nxt = odata_r;
    olast_nxt = olast_r;
    cmd = '0;
    cmd.load_idx = 6'(count_r);
    cmd.upd_idx = cand_r.best_idx;
    cmd.run = run;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      srtf_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (count_r < (IdxW+1)'(MAX_PROCS)) begin
            cmd.load = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            seg_nxt = '0;
            cand_nxt = '0;
            state_nxt = srtf_pkg::ST_SCAN;
          end
        end
      end
      srtf_pkg::ST_SCAN: begin
        cand_nxt = seg_out;
        if (seg_r == SegW'(NSeg - 1)) begin
          state_nxt = srtf_pkg::ST_STEP;
        end else begin
          seg_nxt = seg_r + 1'b1;
        end
      end
      srtf_pkg::ST_STEP: begin
        seg_nxt = '0;
        cand_nxt = '0;
        state_nxt = srtf_pkg::ST_SCAN;
        if (fin_r == count_r) begin
          // set complete (also covers an empty set)
          count_nxt = '0;
          fin_nxt = '0;
          ovf_nxt = 1'b0;
          now_nxt = '0;
          sw_nxt = '0;
          st_nxt = '0;
          cmd.clear = 1'b1;
          state_nxt = srtf_pkg::ST_LOAD;
        end else if (!cand_r.have_best) begin
          now_nxt = srtf_pkg::ClkW'(cand_r.min_arr);
        end else begin
          cmd.update = 1'b1;
          now_nxt = fin_t;
          if (run21 == srtf_pkg::ClkW'(cand_r.best_rem)) begin
            fin_nxt = fin_r + 1'b1;
            sw_nxt = sw_r + srtf_pkg::SumW'(wait_t);
            st_nxt = st_r + srtf_pkg::SumW'(turn);
            odata_nxt = {3'd0, ovf_r, st_r + srtf_pkg::SumW'(turn),
                         sw_r + srtf_pkg::SumW'(wait_t), turn, wait_t, ids[bi]};
            olast_nxt = (fin_r + 1'b1) == count_r;
            state_nxt = srtf_pkg::ST_EMIT;
          end
        end
      end
      srtf_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          seg_nxt = '0;
          cand_nxt = '0;
          state_nxt = srtf_pkg::ST_SCAN;
        end
      end
      default: state_nxt = srtf_pkg::ST_LOAD;
    endcase
  end

  assign out_tdata = odata_r;
  assign out_tlast = olast_r;

  a_fin_le_count: assert property (@(posedge clk) disable iff (!rst_n) fin_r <= count_r)
    else $error("finished count above loaded count");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("load taken during scheduling");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (IdxW+1)'(MAX_PROCS))
    else $error("set over capacity");
endmodule
